FILE: rtl/core/gmp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmp_pkg: shared types and constants for the grid minimum path cost block
// Cost width, sentinel, register indexes and the cell control structures.
// ----------------------------------------------------------------------------
package gmp_pkg;

  localparam int DEF_MAX_ROWS    = 16;
  localparam int DEF_MAX_COLS    = 16;
  localparam int DEF_WEIGHT_BITS = 8;

  localparam int COST_W = 16;
  localparam logic [COST_W-1:0] COST_INF = '1;

  // configuration port
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'd1;
  localparam logic [CFG_W-1:0] SIZE_RESET = 5'd16;

  // column tag of one grid cell
  typedef struct packed {
    logic first;
    logic last;
  } gmp_tag_t;

  // per-cycle command to the cell chain
  typedef struct packed {
    logic shift_up;
    logic shift_down;
    logic tag_shift;
    logic init;
    logic relax;
  } gmp_ctl_t;

  // neighbor costs: left, right, up, down
  typedef struct packed {
    logic [3:0]             ok;
    logic [3:0][COST_W-1:0] cost;
  } gmp_nbr_t;

endpackage

FILE: rtl/core/gmp_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmp_cell: one grid cell of the relaxation chain
// Holds a weight, a column tag and a running cost; passes weight and tag
// to its neighbor and relaxes its cost against the four grid neighbors.
// ----------------------------------------------------------------------------
module gmp_cell import gmp_pkg::*; #(
  parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
  input  logic                   clk,
  input  gmp_ctl_t               ctl,
  input  logic [WEIGHT_BITS-1:0] w_lo,
  input  logic [WEIGHT_BITS-1:0] w_hi,
  input  gmp_tag_t               tag_lo,
  input  logic                   start,
  input  logic                   active,
  input  gmp_nbr_t               nbr,
  output logic [WEIGHT_BITS-1:0] weight,
  output gmp_tag_t               tag,
  output logic [COST_W-1:0]      cost,
  output logic                   changed
);

  logic [COST_W-1:0] mn;
  logic [COST_W:0]   sum;
  logic [COST_W-1:0] cand;

  // least neighbor cost plus own weight, saturating
  always_comb begin
    mn = COST_INF;
    for (int d = 0; d < 4; d++) begin
      if (nbr.ok[d] && nbr.cost[d] < mn) begin
        mn = nbr.cost[d];
      end
    end
    sum  = {1'b0, mn} + (COST_W+1)'(weight);
    cand = sum[COST_W] ? COST_INF : sum[COST_W-1:0];
  end

  // only cells inside the current grid relax
  assign changed = ctl.relax && active && (cand < cost);

  // hold weight, tag and cost
  always_ff @(posedge clk) begin
    if (ctl.shift_up) begin
      weight <= w_lo;
    end else if (ctl.shift_down) begin
      weight <= w_hi;
    end
    if (ctl.tag_shift) begin
      tag <= tag_lo;
    end
    if (ctl.init) begin
      cost <= start ? '0 : COST_INF;
    end else if (changed) begin
      cost <= cand;
    end
  end

endmodule

FILE: rtl/core/grid_min_path_cost.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_min_path_cost: least four-neighbor path cost through a weighted grid
// Weights load one per cycle, while in_stall is low, into a chain of cells; on the last
// weight the chain aligns, tags columns and relaxes all cells in parallel to a fixed point.
// Relax passes: one per cycle, repeated until no cell cost changes.
// Throughput: one weight per cycle during load; a grid blocks input until out.
// Reset: synchronous; rows and cols return to 16, load count clears.
// ----------------------------------------------------------------------------
module grid_min_path_cost import gmp_pkg::*; #(
  parameter int MAX_ROWS    = DEF_MAX_ROWS,
  parameter int MAX_COLS    = DEF_MAX_COLS,
  parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [WEIGHT_BITS-1:0] cell_weight,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [COST_W-1:0]      path_cost
);

  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int CNT_W = $clog2(CELLS + 1);
  localparam int RW    = $clog2(MAX_ROWS + 1);
  localparam int CW    = $clog2(MAX_COLS + 1);

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_ALIGN = 3'd1;
  localparam logic [2:0] S_TAG   = 3'd2;
  localparam logic [2:0] S_INIT  = 3'd3;
  localparam logic [2:0] S_RELAX = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]       state;
  logic [CFG_W-1:0] grid_rows;
  logic [CFG_W-1:0] grid_cols;
  logic [CNT_W-1:0] load_count;
  logic [CNT_W-1:0] load_count_next;
  logic [CNT_W-1:0] align_cnt;
  logic [CNT_W-1:0] tcount;
  logic [CW-1:0]    tcol;
  logic [CNT_W-1:0] total_q;
  logic [CW-1:0]    cols_q;
  logic [RW-1:0]    rows_lim;
  logic [CW-1:0]    cols_lim;
  logic [CNT_W-1:0] total_now;
  logic             in_xfer;
  logic             any_changed;
  gmp_ctl_t         ctl;
  gmp_tag_t         tag_in;

  logic [WEIGHT_BITS-1:0] w_arr    [CELLS];
  gmp_tag_t               tag_arr  [CELLS];
  logic [COST_W-1:0]      cost_arr [CELLS];
  logic [CELLS-1:0]       chg;

  // limit the configured size to the grid the chain can hold; zero counts as one
  always_comb begin
    if (grid_rows == '0) begin
      rows_lim = RW'(1);
    end else if (int'(grid_rows) > MAX_ROWS) begin
      rows_lim = RW'(MAX_ROWS);
    end else begin
      rows_lim = RW'(grid_rows);
    end
    if (grid_cols == '0) begin
      cols_lim = CW'(1);
    end else if (int'(grid_cols) > MAX_COLS) begin
      cols_lim = CW'(MAX_COLS);
    end else begin
      cols_lim = CW'(grid_cols);
    end
    total_now = CNT_W'(rows_lim) * CNT_W'(cols_lim);
  end

  assign in_stall        = (state != S_LOAD);
  assign in_xfer         = in_valid && !in_stall;
  assign load_count_next = load_count + CNT_W'(1);
  assign any_changed     = |chg;

  // chain commands
  always_comb begin
    ctl            = '0;
    ctl.shift_up   = in_xfer;
    ctl.shift_down = (state == S_ALIGN);
    ctl.tag_shift  = (state == S_TAG);
    ctl.init       = (state == S_INIT);
    ctl.relax      = (state == S_RELAX);
    tag_in.first   = (tcol == '0);
    tag_in.last    = (tcol == cols_q - CW'(1));
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows <= SIZE_RESET;
      grid_cols <= SIZE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROWS: grid_rows <= cfg_data;
        REG_COLS: grid_cols <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer: load, align, tag, init, relax, transfer out
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      load_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      case (state)
        S_LOAD: begin
          if (in_xfer) begin
            if (load_count_next >= total_now) begin
              load_count <= '0;
              total_q    <= total_now;
              cols_q     <= cols_lim;
              align_cnt  <= load_count_next - total_now;
              tcount     <= '0;
              tcol       <= '0;
              state      <= (load_count_next == total_now) ? S_TAG : S_ALIGN;
            end else begin
              load_count <= load_count_next;
            end
          end
        end
        S_ALIGN: begin
          align_cnt <= align_cnt - CNT_W'(1);
          if (align_cnt == CNT_W'(1)) begin
            state <= S_TAG;
          end
        end
        S_TAG: begin
          tcount <= tcount + CNT_W'(1);
          tcol   <= (tcol == cols_q - CW'(1)) ? '0 : tcol + CW'(1);
          if (tcount == total_q - CNT_W'(1)) begin
            state <= S_INIT;
          end
        end
        S_INIT: begin
          state <= S_RELAX;
        end
        S_RELAX: begin
          if (!any_changed) begin
            path_cost <= cost_arr[0];
            out_valid <= 1'b1;
            state     <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state     <= S_LOAD;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  // chain of cells: position p holds grid index total-1-p
  for (genvar p = 0; p < CELLS; p++) begin : g_cell
    localparam int P = p;
    logic [WEIGHT_BITS-1:0] w_lo;
    logic [WEIGHT_BITS-1:0] w_hi;
    gmp_tag_t               tag_lo;
    gmp_nbr_t               nbr;
    logic                   start;
    logic                   active;

    always_comb begin
      w_lo   = (P == 0) ? cell_weight : w_arr[(P == 0) ? 0 : P - 1];
      w_hi   = (P == CELLS - 1) ? '0 : w_arr[(P == CELLS - 1) ? P : P + 1];
      tag_lo = (P == 0) ? tag_in : tag_arr[(P == 0) ? 0 : P - 1];
      start  = (P == int'(total_q) - 1);
      active = (P < int'(total_q));
      nbr    = '0;
      // left neighbor in the grid sits one place further along the chain
      if (P + 1 < CELLS) begin
        nbr.ok[0]   = !tag_arr[P].first;
        nbr.cost[0] = cost_arr[(P + 1 < CELLS) ? P + 1 : P];
      end
      // right neighbor
      if (P > 0) begin
        nbr.ok[1]   = !tag_arr[P].last;
        nbr.cost[1] = cost_arr[(P > 0) ? P - 1 : P];
      end
      // up and down: one row away, chosen by the column count
      nbr.ok[2] = (P + int'(cols_q)) < int'(total_q);
      nbr.ok[3] = P >= int'(cols_q);
      for (int k = 1; k <= MAX_COLS; k++) begin
        if (int'(cols_q) == k) begin
          if (P + k < CELLS) begin
            nbr.cost[2] = cost_arr[(P + k < CELLS) ? P + k : P];
          end
          if (P >= k) begin
            nbr.cost[3] = cost_arr[(P >= k) ? P - k : P];
          end
        end
      end
    end

    gmp_cell #(
      .WEIGHT_BITS(WEIGHT_BITS)
    ) u_cell (
      .clk    (clk),
      .ctl    (ctl),
      .w_lo   (w_lo),
      .w_hi   (w_hi),
      .tag_lo (tag_lo),
      .start  (start),
      .active (active),
      .nbr    (nbr),
      .weight (w_arr[P]),
      .tag    (tag_arr[P]),
      .cost   (cost_arr[P]),
      .changed(chg[P])
    );
  end

  // a settled relax pass leads straight to a result
  a_settle_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_RELAX && !any_changed) |=> out_valid)
    else $error("settled relaxation did not raise out_valid");

  // a result only stands in the output state, with input held off
  a_out_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (state == S_OUT && in_stall))
    else $error("out_valid outside output state");

  // the tag pass never runs past the grid
  a_tag_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_TAG) |-> (tcount < total_q))
    else $error("tag counter beyond grid size");

  // relax updates only flag a cost change while relaxing
  a_chg_relax: assert property (@(posedge clk) disable iff (rst)
    any_changed |-> (state == S_RELAX))
    else $error("cost change outside relaxation");

endmodule

FILE: verif/tb_grid_min_path_cost.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_grid_min_path_cost: self-checking bench for the grid minimum path cost
// Streams grids of random weights under several sizes and random idling,
// predicts each least path cost by relaxation and checks every result.
// ----------------------------------------------------------------------------
module tb_grid_min_path_cost;
  import gmp_pkg::*;

  localparam int MR = DEF_MAX_ROWS;
  localparam int MC = DEF_MAX_COLS;

  // tracks the grid being loaded and the costs still to arrive
  class cost_board;
    int unsigned rows_reg, cols_reg;
    int unsigned weights[MR*MC];
    int unsigned loaded;
    logic [COST_W-1:0] pending[$];
    int unsigned errors;

    function new();
      rows_reg = SIZE_RESET;
      cols_reg = SIZE_RESET;
      loaded = 0;
      errors = 0;
    endfunction

    function int unsigned clip(int unsigned v, int unsigned mx);
      if (v < 1) return 1;
      if (v > mx) return mx;
      return v;
    endfunction

    // relax to a fixed point over the loaded weights
    function logic [COST_W-1:0] least_cost(int unsigned rows, int unsigned cols);
      int unsigned cost[MR*MC];
      int unsigned cand, here, from;
      int nr, nc;
      bit changed;
      for (int i = 0; i < rows*cols; i++) cost[i] = COST_INF;
      cost[0] = 0;
      changed = 1;
      while (changed) begin
        changed = 0;
        for (int r = 0; r < rows; r++) begin
          for (int c = 0; c < cols; c++) begin
            here = r*cols + c;
            for (int d = 0; d < 4; d++) begin
              nr = r + ((d == 0) ? -1 : (d == 1) ? 1 : 0);
              nc = c + ((d == 2) ? -1 : (d == 3) ? 1 : 0);
              if (nr < 0 || nc < 0 || nr >= rows || nc >= cols) continue;
              from = nr*cols + nc;
              cand = cost[from] + weights[here];
              if (cand > COST_INF) cand = COST_INF;
              if (cand < cost[here]) begin
                cost[here] = cand;
                changed = 1;
              end
            end
          end
        end
      end
      return cost[rows*cols-1];
    endfunction

    function void note_weight(logic [7:0] w);
      int unsigned rows, cols;
      rows = clip(rows_reg, MR);
      cols = clip(cols_reg, MC);
      if (loaded < MR*MC) weights[loaded] = w;
      loaded++;
      if (loaded >= rows*cols) begin
        loaded = 0;
        pending.push_back(least_cost(rows, cols));
      end
    endfunction

    function void check_cost(logic [COST_W-1:0] got);
      logic [COST_W-1:0] want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected path_cost %0d", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("path_cost mismatch: expected %0d actual %0d", want, got);
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_ROWS;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 0, out_stall = 0;
  logic [7:0] cell_weight = '0;
  logic in_stall, out_valid;
  logic [COST_W-1:0] path_cost;

  cost_board board = new();
  int send_idle = 6, recv_idle = 72;
  int hold_cycles = 0;
  bit hold_req = 0;
  bit hold_seen = 0;
  int sent = 0;

  grid_min_path_cost DUT (.*);

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  // sample results
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) board.check_cost(path_cost);
  end

  // receiver stall, with one long hold-off on request
  always @(negedge clk) begin
    if (hold_req && !hold_seen) begin
      hold_seen <= 1;
      hold_cycles <= 400;
      out_stall <= 1;
    end else if (hold_cycles > 0) begin
      out_stall <= 1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    in_valid <= 0;
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
    if (idx == REG_ROWS) board.rows_reg = val;
    else board.cols_reg = val;
  endtask

  // offer one weight and wait for its transfer
  task automatic send_weight(logic [7:0] w);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    cell_weight <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_weight(w);
    sent++;
    @(negedge clk);
  endtask

  // drain all results, then let the block settle
  task automatic drain();
    in_valid <= 0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (600) @(negedge clk);
  endtask

  task automatic send_grid(int cells, int mode);
    for (int i = 0; i < cells; i++) begin
      case (mode)
        0: send_weight(8'($urandom_range(255)));
        1: send_weight(8'hFF);
        2: send_weight(8'h00);
        default: send_weight(($urandom_range(3) == 0) ? 8'hFF : 8'($urandom_range(9)));
      endcase
    end
  endtask

  task automatic set_size(int r, int c);
    drain();
    write_reg(REG_ROWS, CFG_W'(r));
    write_reg(REG_COLS, CFG_W'(c));
  endtask

  initial begin
    int r, c;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // directed: single cell, out-of-range sizes, extremes
    set_size(1, 1);
    send_grid(3, 0);
    set_size(0, 0);
    send_grid(2, 1);
    set_size(2, 3);
    send_grid(6, 1);
    send_grid(6, 2);
    set_size(31, 1);
    send_grid(16, 0);
    // size change mid-load: the grid finishes at the new count
    set_size(4, 4);
    send_weight(8'hAA);
    send_weight(8'h55);
    write_reg(REG_COLS, 1);
    send_weight(8'h01);
    send_weight(8'h80);
    drain();
    // full size once with saturating weights
    set_size(16, 16);
    send_grid(256, 1);
    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        send_idle = 72;
        recv_idle = 6;
      end else if (phase == 2) begin
        send_idle = 0;
        recv_idle = 0;
      end
      while (sent < 700 * (phase + 1)) begin
        r = ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(1, 5);
        c = ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(1, 5);
        set_size(r, c);
        if (phase == 2 && sent > 1500)
          hold_req = 1;
        for (int g = 0; g < $urandom_range(1, 4); g++)
          send_grid(board.clip(r, MR) * board.clip(c, MC), $urandom_range(3));
      end
    end
    drain();
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("*** FAILED ***");
    $finish;
  end
endmodule

FILE: filelist.f
rtl/core/gmp_pkg.sv
rtl/core/gmp_cell.sv
rtl/core/grid_min_path_cost.sv
verif/tb_grid_min_path_cost.sv
